[rtl/fcdws_pkg.sv]
// Shared types, constants and pixel functions for the font column doubler.
// No dependencies; every other file of the block imports this package.
package fcdws_pkg;

   localparam int COL_W        = 7;   // font column height
   localparam int STR_W        = 13;  // stretched column height
   localparam int WORD_W       = 14;  // display column word
   localparam int GLYPH_W      = 8;   // glyph width register
   localparam int MAX_WORDS    = 5;   // most words one font column can cause
   localparam int WORD_IDX_W   = $clog2(MAX_WORDS + 1);
   localparam int QUEUE_DEPTH  = 2;
   localparam int QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 8;

   localparam logic [GLYPH_W-1:0] GLYPH_WIDTH_RESET = 8'd8;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_GLYPH_WIDTH     = 2'd0,
      REG_BOLD_ENABLE     = 2'd1,
      REG_COMPRESS_ENABLE = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [GLYPH_W-1:0] glyph_width;
      logic               bold_enable;
      logic               compress_enable;
   } cfg_type;

   // All words caused by one font column, in output order.
   typedef struct packed {
      logic [MAX_WORDS-1:0][WORD_W-1:0] words;
      logic [WORD_IDX_W-1:0]            count;
   } job_type;

   typedef struct packed {
      logic can_push;
      logic has_data;
   } queue_status_type;

   // Move source bit i to bit 2i, set odd bits between two set neighbors.
   function automatic logic [STR_W-1:0] stretch7(input logic [COL_W-1:0] c);
      logic [STR_W-1:0] y;
      y = '0;
      for (int i = 0; i < COL_W; i++) begin
         y[2*i] = c[i];
      end
      return y | ((y << 1) & (y >> 1));
   endfunction

   // OR a column with itself shifted down one row.
   function automatic logic [WORD_W-1:0] thicken(input logic [WORD_W-1:0] v);
      return v | (v << 1);
   endfunction

endpackage

[rtl/fcdws_if.sv]
// Valid/ready channel interfaces for the font column doubler.
// Depends on fcdws_pkg for field widths.
interface fcdws_req_if;
   import fcdws_pkg::*;
   logic             valid;
   logic             ready;
   logic [COL_W-1:0] column_bits;
   logic             end_mark;
   modport source (output valid, output column_bits, output end_mark, input ready);
   modport sink   (input valid, input column_bits, input end_mark, output ready);
endinterface

interface fcdws_rsp_if;
   import fcdws_pkg::*;
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] column_word;
   logic              run_last;
   modport source (output valid, output column_word, output run_last, input ready);
   modport sink   (input valid, input column_word, input run_last, output ready);
endinterface

interface fcdws_csr_if;
   import fcdws_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/fcdws_csr.sv]
// Configuration registers: glyph width, bold and compressed mode.
// Depends on fcdws_pkg and fcdws_csr_if.
module fcdws_csr (
   input  logic               clock,
   input  logic               reset,
   fcdws_csr_if.sink          csr,
   output fcdws_pkg::cfg_type cfg
);
   import fcdws_pkg::*;

   cfg_type cfg_ff, cfg_in;

   // Always take writes; unknown indexes drop the word
   assign csr.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr.valid) begin
         case (csr_index_type'(csr.index))
            REG_GLYPH_WIDTH:     cfg_in.glyph_width     = csr.data;
            REG_BOLD_ENABLE:     cfg_in.bold_enable     = csr.data[0];
            REG_COMPRESS_ENABLE: cfg_in.compress_enable = csr.data[0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.glyph_width     <= GLYPH_WIDTH_RESET;
         cfg_ff.bold_enable     <= 1'b0;
         cfg_ff.compress_enable <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[rtl/fcdws_front.sv]
// Front end: takes font columns, builds the words each one causes and
// tracks glyph state. Depends on fcdws_pkg and fcdws_req_if.
module fcdws_front (
   input  logic                        clock,
   input  logic                        reset,
   fcdws_req_if.sink                   req,
   input  fcdws_pkg::cfg_type          cfg,
   input  fcdws_pkg::queue_status_type qstat,
   output logic                        push,
   output fcdws_pkg::job_type          job
);
   import fcdws_pkg::*;

   logic               at_start_ff, at_start_in;
   logic [GLYPH_W-1:0] taken_ff, taken_in;
   logic [STR_W-1:0]   prev_str_ff;
   logic [WORD_W-1:0]  prev_drawn_ff;

   logic [STR_W-1:0]      cur;
   logic [STR_W-1:0]      mid;
   logic [WORD_W-1:0]     drawn;
   logic [WORD_W-1:0]     bold_mid;
   logic [WORD_W-1:0]     w1;
   logic [WORD_W-1:0]     w2;
   logic [GLYPH_W-1:0]    taken_next;
   logic                  glyph_end;
   logic [WORD_IDX_W-1:0] n;

   assign req.ready = qstat.can_push;
   assign push      = req.valid && qstat.can_push;

   // Stretch, interpolate and thicken
   always_comb begin
      cur      = stretch7(req.column_bits);
      drawn    = cfg.bold_enable ? thicken({1'b0, cur}) : {1'b0, cur};
      mid      = (prev_str_ff & cur) |
                 (~(prev_str_ff | cur) & (((prev_str_ff >> 1) & (cur << 1)) |
                                          ((prev_str_ff << 1) & (cur >> 1))));
      bold_mid = thicken({1'b0, mid});
      if (cfg.bold_enable) begin
         w1 = bold_mid | prev_drawn_ff;
         w2 = drawn | bold_mid;
      end else begin
         w1 = {1'b0, mid};
         w2 = {1'b0, cur};
      end
   end

   // Assemble the word list for this column
   always_comb begin
      job.words = '0;
      if (at_start_ff) begin
         job.words[0] = drawn;
         n            = WORD_IDX_W'(1);
         taken_next   = GLYPH_W'(1);
      end else begin
         taken_next = taken_ff + GLYPH_W'(1);
         if (cfg.compress_enable) begin
            job.words[0] = w1 | w2;
            n            = WORD_IDX_W'(1);
         end else begin
            job.words[0] = w1;
            job.words[1] = w2;
            n            = WORD_IDX_W'(2);
         end
      end
      glyph_end = req.end_mark || (taken_next >= cfg.glyph_width);
      // Trailing words at a glyph end: a blank, or with bold the last drawn column and two blanks
      if (glyph_end && cfg.bold_enable) begin
         job.words[n] = drawn;
         job.count    = n + WORD_IDX_W'(3);
      end else if (glyph_end) begin
         job.count    = n + WORD_IDX_W'(1);
      end else begin
         job.count    = n;
      end
      at_start_in = glyph_end;
      taken_in    = glyph_end ? '0 : taken_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         at_start_ff   <= 1'b1;
         taken_ff      <= '0;
         prev_str_ff   <= '0;
         prev_drawn_ff <= '0;
      end else if (push) begin
         at_start_ff   <= at_start_in;
         taken_ff      <= taken_in;
         prev_str_ff   <= cur;
         prev_drawn_ff <= drawn;
      end
   end

endmodule

[rtl/fcdws_queue.sv]
// Short job queue between front and back end.
// Depends on fcdws_pkg.
module fcdws_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  fcdws_pkg::job_type          push_job,
   input  logic                        pop,
   output fcdws_pkg::job_type          head,
   output fcdws_pkg::queue_status_type qstat
);
   import fcdws_pkg::*;

   job_type                entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] cnt_ff, cnt_in;

   assign qstat.can_push = (cnt_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
   assign qstat.has_data = (cnt_ff != '0);
   assign head           = entries_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Store entry payload
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

[rtl/fcdws_back.sv]
// Back end: walks the head job's words into the output register, one word
// per cycle while rsp is ready. Depends on fcdws_pkg and fcdws_rsp_if.
module fcdws_back (
   input  logic                        clock,
   input  logic                        reset,
   input  fcdws_pkg::job_type          head,
   input  fcdws_pkg::queue_status_type qstat,
   output logic                        pop,
   fcdws_rsp_if.source                 rsp
);
   import fcdws_pkg::*;

   logic [WORD_IDX_W-1:0] idx_ff, idx_in;
   logic                  valid_ff, valid_in;
   logic [WORD_W-1:0]     word_ff, word_in;
   logic                  last_ff, last_in;
   logic                  load;
   logic                  is_last;

   assign load    = !valid_ff || rsp.ready;
   assign is_last = (idx_ff == head.count - WORD_IDX_W'(1));
   assign pop     = load && qstat.has_data && is_last;

   // Pick the next word and step through the job
   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      word_in  = word_ff;
      last_in  = last_ff;
      if (load) begin
         valid_in = qstat.has_data;
         word_in  = head.words[idx_ff];
         last_in  = is_last;
         if (qstat.has_data) begin
            idx_in = is_last ? '0 : idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   // Hold payload while the receiver stalls
   always_ff @(posedge clock) begin
      word_ff <= word_in;
      last_ff <= last_in;
   end

   assign rsp.valid       = valid_ff;
   assign rsp.column_word = word_ff;
   assign rsp.run_last    = last_ff;

endmodule

[rtl/font_column_double_with_smoothing.sv]
// Top level of the font column doubler with smoothing.
// Depends on fcdws_pkg, the channel interfaces and all fcdws_ modules.
//
// Usage:
//   req_ch takes one 7-bit font column and an end-of-glyph mark per word.
//   rsp_ch returns 14-bit display column words; run_last marks the final
//   word caused by each font column. Every column causes 1 to 5 words.
//   csr_ch writes glyph_width (index 0), bold_enable (1), compress_enable (2);
//   the user must write only while the block is idle, which the block itself does not enforce; csr_ch is always ready.
// Timing:
//   The front end builds all of a column's words in the accept cycle and
//   pushes them as one job into a two-entry job queue, which lets it take
//   new columns while the back end is still sending. The back end sends
//   the words through its output register, one word per cycle while
//   rsp_ch is ready. A column has 2 words in plain glyph body, 1
//   compressed, up to 5 at a glyph end.
// Reset:
//   Synchronous; clears queue, output valid and glyph state, and loads the
//   register defaults (width 8, bold and compression off).
// Stalls:
//   A stalled rsp_ch holds its word; req_ch drops ready once the queue fills.
module font_column_double_with_smoothing (
   input  logic         clock,
   input  logic         reset,
   fcdws_req_if.sink    req_ch,
   fcdws_rsp_if.source  rsp_ch,
   fcdws_csr_if.sink    csr_ch
);
   import fcdws_pkg::*;

   cfg_type          cfg;
   queue_status_type qstat;
   job_type          push_job;
   job_type          head;
   logic             push;
   logic             pop;

   fcdws_csr u_csr (
      .clock (clock),
      .reset (reset),
      .csr   (csr_ch),
      .cfg   (cfg)
   );

   fcdws_front u_front (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .cfg   (cfg),
      .qstat (qstat),
      .push  (push),
      .job   (push_job)
   );

   fcdws_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head     (head),
      .qstat    (qstat)
   );

   fcdws_back u_back (
      .clock (clock),
      .reset (reset),
      .head  (head),
      .qstat (qstat),
      .pop   (pop),
      .rsp   (rsp_ch)
   );

   // Never retire a job from an empty queue
   a_pop_has_data: assert property (@(posedge clock) disable iff (reset)
      pop |-> qstat.has_data)
      else $error("job popped from empty queue");

   // Every pushed job carries between one and MAX_WORDS words
   a_job_count: assert property (@(posedge clock) disable iff (reset)
      push |-> (push_job.count != '0) && (push_job.count <= WORD_IDX_W'(MAX_WORDS)))
      else $error("job word count out of range");

   // Retiring a job loads its final word into the output register
   a_pop_marks_last: assert property (@(posedge clock) disable iff (reset)
      pop |=> rsp_ch.valid && rsp_ch.run_last)
      else $error("job retired without final word");

   // Queue and output register are empty right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !qstat.has_data && !rsp_ch.valid)
      else $error("state left over after reset");

endmodule
